// File: rtl/core/pubf_pkg.sv
package pubf_pkg;

  localparam int FIFO_DEPTH_DEF = 128;
  localparam int BYTE_W = 8;

  typedef enum logic [1:0] {
    EV_READ   = 2'd0,
    EV_WRITE  = 2'd1,
    EV_RX     = 2'd2,
    EV_TXDONE = 2'd3
  } ev_t;

  typedef enum logic [1:0] {
    DIR_IDLE  = 2'd0,
    DIR_READ  = 2'd1,
    DIR_WRITE = 2'd2
  } dir_t;

  typedef logic [BYTE_W-1:0] byte_t;

  // Control handed from the bridge to the cell row for one cycle.
  typedef struct packed {
    logic shift;
    logic push;
  } chain_ctrl_t;

endpackage

// File: rtl/core/pubf_req_if.sv
interface pubf_req_if;
  logic                 valid;
  logic                 ready;
  logic [1:0]           mode;
  logic [7:0]           bus_byte;
  logic [7:0]           rx_byte;

  modport source (output valid, output mode, output bus_byte, output rx_byte, input ready);
  modport sink (input valid, input mode, input bus_byte, input rx_byte, output ready);
endinterface

// File: rtl/core/pubf_rsp_if.sv
interface pubf_rsp_if;
  logic       valid;
  logic       ready;
  logic       status_ready;
  logic [7:0] out_byte;
  logic       bus_drive;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic [1:0] bridge_mode;

  modport source (
    output valid, output status_ready, output out_byte, output bus_drive,
    output tx_valid, output tx_byte, output bridge_mode, input ready
  );
  modport sink (
    input valid, input status_ready, input out_byte, input bus_drive,
    input tx_valid, input tx_byte, input bridge_mode, output ready
  );
endinterface

// File: rtl/core/parallel_uart_bridge_fifo_core.sv
// Channel | Dir | Payload                                         | Handshake
// req     | in  | mode, bus_byte, rx_byte                         | valid/ready
// rsp     | out | status_ready, out_byte, bus_drive, tx_valid,    | valid/ready
//         |     | tx_byte, bridge_mode                            |
//
// Each request is handled combinationally; its response appears in the output
// register on the next cycle, so one request per cycle is sustained while rsp.ready stays high.
// The receive queue is a row of byte cells that shifts toward the front on a pop.
// req.ready is low only while a response waits in the output register and
// rsp.ready is low. Synchronous reset clears all control state; queue cells
// hold no reset and are never read before they are written.
module parallel_uart_bridge_fifo_core #(
  parameter int FIFO_DEPTH = pubf_pkg::FIFO_DEPTH_DEF
) (
  input logic       clk,
  input logic       rst,
  pubf_req_if.sink  req,
  pubf_rsp_if.source rsp
);
  import pubf_pkg::*;

  localparam int IdxW = $clog2(FIFO_DEPTH);
  localparam int CntW = $clog2(FIFO_DEPTH + 1);

  dir_t            dir, dir_next;
  logic            rd_phase, rd_phase_next;
  logic            wr_phase, wr_phase_next;
  logic [CntW-1:0] count, count_next;
  logic            ready_flag, ready_flag_next;
  byte_t           bus_out, bus_out_next;
  logic            txv;
  byte_t           txb;

  chain_ctrl_t     ctrl;
  logic [IdxW-1:0] push_idx;
  byte_t           head_byte;
  byte_t           next_byte;
  logic            accept;
  logic            full;
  ev_t             ev;

  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign ev        = ev_t'(req.mode);
  assign full      = (count == CntW'(FIFO_DEPTH));

  pubf_chain #(.Depth(FIFO_DEPTH)) u_chain (
    .clk       (clk),
    .ctrl      (ctrl),
    .push_idx  (push_idx),
    .wdata     (req.rx_byte),
    .head_byte (head_byte),
    .next_byte (next_byte)
  );

  // Direction state machine: counted strobe changes move it.
  always_comb begin
    dir_next = dir;
    if (accept) begin
      case (ev)
        EV_READ:  if (!rd_phase) dir_next = DIR_READ;
        EV_WRITE: if (!wr_phase) dir_next = DIR_WRITE;
        default:  dir_next = dir;
      endcase
    end
  end

  always_comb begin
    rd_phase_next   = rd_phase;
    wr_phase_next   = wr_phase;
    count_next      = count;
    ready_flag_next = ready_flag;
    bus_out_next    = bus_out;
    txv             = 1'b0;
    txb             = '0;
    ctrl            = '0;
    push_idx        = full ? '0 : count[IdxW-1:0];
    if (accept) begin
      case (ev)
        EV_READ: begin
          rd_phase_next = !rd_phase;
          if (!rd_phase) begin
            if (dir != DIR_READ) begin
              count_next      = '0;
              ready_flag_next = 1'b0;
            end else if (count != '0) begin
              ctrl.shift = 1'b1;
              count_next = count - CntW'(1);
              if (count == CntW'(1)) begin
                ready_flag_next = 1'b0;
              end else begin
                bus_out_next = next_byte;
              end
            end
          end
        end
        EV_WRITE: begin
          wr_phase_next = !wr_phase;
          if (!wr_phase) begin
            if (dir == DIR_WRITE) begin
              ready_flag_next = 1'b0;
              txv             = 1'b1;
              txb             = req.bus_byte;
            end else begin
              if (dir == DIR_READ) begin
                bus_out_next = '0;
              end
              ready_flag_next = 1'b1;
            end
          end
        end
        EV_RX: begin
          if (dir == DIR_READ) begin
            // A full queue is dropped and the new byte becomes its only entry.
            ctrl.push       = 1'b1;
            count_next      = full ? CntW'(1) : count + CntW'(1);
            bus_out_next    = (full || count == '0) ? req.rx_byte : head_byte;
            ready_flag_next = 1'b1;
          end
        end
        EV_TXDONE: begin
          if (dir == DIR_WRITE) begin
            ready_flag_next = 1'b1;
          end
        end
        default: begin
          ready_flag_next = ready_flag;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dir        <= DIR_IDLE;
      rd_phase   <= 1'b0;
      wr_phase   <= 1'b0;
      count      <= '0;
      ready_flag <= 1'b0;
      bus_out    <= '0;
      rsp.valid  <= 1'b0;
    end else begin
      dir        <= dir_next;
      rd_phase   <= rd_phase_next;
      wr_phase   <= wr_phase_next;
      count      <= count_next;
      ready_flag <= ready_flag_next;
      bus_out    <= bus_out_next;
      rsp.valid  <= accept || (rsp.valid && !rsp.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status_ready <= ready_flag_next;
      rsp.out_byte     <= bus_out_next;
      rsp.bus_drive    <= (dir_next == DIR_READ);
      rsp.tx_valid     <= txv;
      rsp.tx_byte      <= txb;
      rsp.bridge_mode  <= dir_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(FIFO_DEPTH))
    else $error("queue count exceeds depth");

  a_ready_nonempty: assert property (@(posedge clk) disable iff (rst)
    (dir == DIR_READ && ready_flag) |-> count != '0)
    else $error("ready in read mode with an empty queue");

  a_push_nonempty: assert property (@(posedge clk) disable iff (rst)
    (accept && ev == EV_RX && dir == DIR_READ) |=> count != '0)
    else $error("queue empty after a received byte");

  a_read_phase: assert property (@(posedge clk) disable iff (rst)
    (accept && ev == EV_READ) |=> rd_phase != $past(rd_phase))
    else $error("read strobe phase did not toggle");

  a_tx_in_write: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.tx_valid) |-> rsp.bridge_mode == DIR_WRITE)
    else $error("transmit request outside write mode");

endmodule

// File: rtl/core/pubf_cell.sv
module pubf_cell (
  input  logic           clk,
  input  logic           shift,
  input  logic           wr,
  input  pubf_pkg::byte_t wdata,
  input  pubf_pkg::byte_t right,
  output pubf_pkg::byte_t data
);
  import pubf_pkg::*;

  byte_t store;

  // A write targets exactly one cell; a pop moves every byte one place toward the front.
  always_ff @(posedge clk) begin
    if (wr) begin
      store <= wdata;
    end else if (shift) begin
      store <= right;
    end
  end

  assign data = store;

endmodule

// File: rtl/core/pubf_chain.sv
module pubf_chain #(
  parameter int Depth = pubf_pkg::FIFO_DEPTH_DEF
) (
  input  logic                     clk,
  input  pubf_pkg::chain_ctrl_t    ctrl,
  input  logic [$clog2(Depth)-1:0] push_idx,
  input  pubf_pkg::byte_t          wdata,
  output pubf_pkg::byte_t          head_byte,
  output pubf_pkg::byte_t          next_byte
);
  import pubf_pkg::*;

  localparam int IdxW = $clog2(Depth);

  byte_t cell_data [Depth];

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    byte_t right;
    logic  wr;

    if (i == Depth - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid
      assign right = cell_data[i+1];
    end

    assign wr = ctrl.push && (push_idx == IdxW'(i));

    pubf_cell u_cell (
      .clk   (clk),
      .shift (ctrl.shift),
      .wr    (wr),
      .wdata (wdata),
      .right (right),
      .data  (cell_data[i])
    );
  end

  assign head_byte = cell_data[0];
  assign next_byte = cell_data[1];

endmodule

// File: tb/sv/pubf_tb_pkg.sv
package pubf_tb_pkg;
  import pubf_pkg::*;

  // Tracks the bridge state as the block should see it and checks each
  // response against the status predicted for the oldest open request.
  class bridge_scoreboard #(parameter int DEPTH = FIFO_DEPTH_DEF);

    typedef struct {
      logic  status_ready;
      byte_t out_byte;
      logic  bus_drive;
      logic  tx_valid;
      byte_t tx_byte;
      dir_t  bridge_mode;
    } bridge_status_t;

    dir_t           direction;
    bit             read_phase;
    bit             write_phase;
    byte_t          rx_ring[DEPTH];
    int unsigned    ring_head;
    int unsigned    ring_count;
    bit             ready_line;
    byte_t          bus_latch;
    bridge_status_t expected_status[$];
    int             errors;
    int             requests;
    int             responses;
    int             overflows;
    int             sends;
    int             pops;

    function new();
      direction   = DIR_IDLE;
      read_phase  = 0;
      write_phase = 0;
      ring_head   = 0;
      ring_count  = 0;
      ready_line  = 0;
      bus_latch   = '0;
      errors      = 0;
      requests    = 0;
      responses   = 0;
      overflows   = 0;
      sends       = 0;
      pops        = 0;
    endfunction

    function int open_requests();
      return expected_status.size();
    endfunction

    // Advances the bridge state by one accepted request and queues the
    // status the block has to report for it.
    function void note_event(ev_t ev, byte_t bus, byte_t rx);
      bridge_status_t st;
      st.tx_valid = 0;
      st.tx_byte  = '0;
      requests++;
      case (ev)
        EV_READ: begin
          if (!read_phase) begin
            if (direction != DIR_READ) begin
              direction  = DIR_READ;
              ring_count = 0;
              ready_line = 0;
            end else if (ring_count > 0) begin
              ring_head = (ring_head + 1) % DEPTH;
              ring_count--;
              pops++;
              if (ring_count == 0) ready_line = 0;
              else bus_latch = rx_ring[ring_head];
            end
          end
          read_phase = !read_phase;
        end
        EV_WRITE: begin
          if (!write_phase) begin
            if (direction == DIR_WRITE) begin
              ready_line  = 0;
              st.tx_valid = 1;
              st.tx_byte  = bus;
              sends++;
            end else begin
              if (direction == DIR_READ) bus_latch = '0;
              direction  = DIR_WRITE;
              ready_line = 1;
            end
          end
          write_phase = !write_phase;
        end
        EV_RX: begin
          if (direction == DIR_READ) begin
            // A full queue is dropped and the new byte becomes its only entry.
            if (ring_count >= DEPTH) begin
              ring_count = 0;
              overflows++;
            end
            rx_ring[(ring_head + ring_count) % DEPTH] = rx;
            ring_count++;
            bus_latch  = rx_ring[ring_head];
            ready_line = 1;
          end
        end
        default: begin
          if (direction == DIR_WRITE) ready_line = 1;
        end
      endcase
      st.status_ready = ready_line;
      st.out_byte     = bus_latch;
      st.bus_drive    = (direction == DIR_READ);
      st.bridge_mode  = direction;
      expected_status.push_back(st);
    endfunction

    function void compare_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_status(logic status_ready, logic [7:0] out_byte, logic bus_drive,
                               logic tx_valid, logic [7:0] tx_byte, logic [1:0] bridge_mode);
      bridge_status_t want;
      responses++;
      if (expected_status.size() == 0) begin
        $error("response with no open request: mode %0h out_byte %0h", bridge_mode, out_byte);
        errors++;
        return;
      end
      want = expected_status.pop_front();
      compare_field("status_ready", 8'(want.status_ready), 8'(status_ready));
      compare_field("out_byte", want.out_byte, out_byte);
      compare_field("bus_drive", 8'(want.bus_drive), 8'(bus_drive));
      compare_field("tx_valid", 8'(want.tx_valid), 8'(tx_valid));
      compare_field("tx_byte", want.tx_byte, tx_byte);
      compare_field("bridge_mode", 8'(want.bridge_mode), 8'(bridge_mode));
    endfunction

  endclass

endpackage

// File: tb/sv/parallel_uart_bridge_fifo_core_tb.sv
module parallel_uart_bridge_fifo_core_tb;
  import pubf_pkg::*;
  import pubf_tb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TARGET_REQUESTS = 1150;
  localparam int STALL_LIMIT     = 5000;
  localparam int HOLD_CYCLES     = 200;

  logic clk;
  logic rst;

  pubf_req_if req_ch ();
  pubf_rsp_if rsp_ch ();

  bridge_scoreboard #(FIFO_DEPTH_DEF) board;

  int  sent;
  bit  hold_done;
  int  hold_left;

  parallel_uart_bridge_fifo_core #(
    .FIFO_DEPTH(FIFO_DEPTH_DEF)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always #5 clk = ~clk;

  function automatic byte_t any_byte();
    return byte_t'($urandom_range(0, 255));
  endfunction

  // Offers one request and returns at the edge that accepts it. Gaps are
  // skipped inside the burst window so the block sees back-to-back traffic.
  task automatic send_request(ev_t ev, byte_t bus, byte_t rx);
    if (sent < 150 || sent >= 350) begin
      while ($urandom_range(0, 99) < 34) begin
        req_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    req_ch.valid    <= 1'b1;
    req_ch.mode     <= ev;
    req_ch.bus_byte <= bus;
    req_ch.rx_byte  <= rx;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    board.note_event(ev, bus, rx);
    sent++;
  endtask

  task automatic strobe_pair(ev_t ev, byte_t bus);
    send_request(ev, bus, any_byte());
    send_request(ev, any_byte(), any_byte());
  endtask

  task automatic send_noise();
    send_request(ev_t'($urandom_range(0, 3)), any_byte(), any_byte());
  endtask

  task automatic read_session();
    int n;
    int pick;
    n = $urandom_range(4, 40);
    strobe_pair(EV_READ, any_byte());
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) send_request(EV_RX, any_byte(), any_byte());
      else if (pick < 85) strobe_pair(EV_READ, any_byte());
      else if (pick < 92) send_request(EV_TXDONE, any_byte(), any_byte());
      else send_noise();
    end
  endtask

  task automatic write_session();
    int n;
    int pick;
    n = $urandom_range(3, 20);
    strobe_pair(EV_WRITE, any_byte());
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) strobe_pair(EV_WRITE, any_byte());
      else if (pick < 80) send_request(EV_TXDONE, any_byte(), any_byte());
      else if (pick < 88) send_request(EV_RX, any_byte(), any_byte());
      else send_noise();
    end
  endtask

  // Enough received bytes without a pop to wrap past a full queue.
  task automatic fill_session();
    int n;
    n = FIFO_DEPTH_DEF + $urandom_range(2, 8);
    strobe_pair(EV_READ, any_byte());
    repeat (n) send_request(EV_RX, any_byte(), any_byte());
    repeat ($urandom_range(1, 6)) strobe_pair(EV_READ, any_byte());
  endtask

  // Receiver: checks each response, stalls at random, and once holds off
  // long enough for the block to back up into its input.
  initial begin
    rsp_ch.ready = 1'b0;
    hold_done    = 0;
    hold_left    = 0;
    wait (rst === 1'b0);
    forever begin
      @(posedge clk);
      if (rsp_ch.valid && rsp_ch.ready)
        board.check_status(rsp_ch.status_ready, rsp_ch.out_byte, rsp_ch.bus_drive,
                           rsp_ch.tx_valid, rsp_ch.tx_byte, rsp_ch.bridge_mode);
      if (!hold_done && board.responses >= 500) begin
        hold_done = 1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (board.responses >= 150 && board.responses < 350) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= 34);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("stalled for %0d cycles with %0d requests open", quiet, board.open_requests());
    $display("parallel_uart_bridge_fifo_core verification failed");
    $finish;
  end

  initial begin
    int  pick;
    bit  filled;
    bit  drained;
    board           = new();
    clk             = 1'b0;
    rst             = 1'b1;
    sent            = 0;
    filled          = 0;
    drained         = 0;
    req_ch.valid    = 1'b0;
    req_ch.mode     = EV_READ;
    req_ch.bus_byte = '0;
    req_ch.rx_byte  = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: ignored events while idle, entering read mode, a pop on an
    // empty queue, pops down to empty, the switch from read to write mode,
    // sending in write mode and the transmit-done handshake.
    send_request(EV_TXDONE, 8'hff, 8'h00);
    send_request(EV_RX, 8'h00, 8'hff);
    send_request(EV_READ, 8'h00, 8'h00);
    send_request(EV_READ, 8'hff, 8'hff);
    send_request(EV_READ, 8'h00, 8'h00);
    send_request(EV_READ, 8'h00, 8'h00);
    send_request(EV_RX, 8'hff, 8'h00);
    send_request(EV_RX, 8'h00, 8'hff);
    send_request(EV_RX, 8'h5a, 8'ha5);
    send_request(EV_READ, 8'h00, 8'h00);
    send_request(EV_READ, 8'h00, 8'h00);
    send_request(EV_READ, 8'h00, 8'h00);
    send_request(EV_READ, 8'h00, 8'h00);
    send_request(EV_READ, 8'h00, 8'h00);
    send_request(EV_READ, 8'h00, 8'h00);
    send_request(EV_TXDONE, 8'h00, 8'h00);
    send_request(EV_RX, 8'h00, 8'h3c);
    send_request(EV_WRITE, 8'hff, 8'h00);
    send_request(EV_WRITE, 8'h00, 8'h00);
    send_request(EV_WRITE, 8'hff, 8'h00);
    send_request(EV_WRITE, 8'h00, 8'h00);
    send_request(EV_TXDONE, 8'h00, 8'h00);
    send_request(EV_WRITE, 8'h00, 8'hff);
    send_request(EV_WRITE, 8'hff, 8'hff);
    send_request(EV_READ, 8'h00, 8'h00);

    while (sent < TARGET_REQUESTS) begin
      if (!drained && sent >= 800) begin
        // Let every open request come back before offering more.
        drained = 1;
        req_ch.valid <= 1'b0;
        while (board.open_requests() != 0) @(posedge clk);
      end
      if (!filled && sent >= 450) begin
        filled = 1;
        fill_session();
      end
      pick = $urandom_range(0, 99);
      if (pick < 40) read_session();
      else if (pick < 72) write_session();
      else if (pick < 75) fill_session();
      else repeat ($urandom_range(1, 10)) send_noise();
    end
    req_ch.valid <= 1'b0;

    while (board.open_requests() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d requests, %0d responses checked, %0d mismatches",
             board.requests, board.responses, board.errors);
    $display("%0d queue pops, %0d queue overflows, %0d bytes sent to the transmitter",
             board.pops, board.overflows, board.sends);
    if (board.errors == 0)
      $display("parallel_uart_bridge_fifo_core verification clean");
    else
      $display("parallel_uart_bridge_fifo_core verification failed");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/pubf_pkg.sv
rtl/core/pubf_req_if.sv
rtl/core/pubf_rsp_if.sv
rtl/core/pubf_cell.sv
rtl/core/pubf_chain.sv
rtl/core/parallel_uart_bridge_fifo_core.sv
tb/sv/pubf_tb_pkg.sv
tb/sv/parallel_uart_bridge_fifo_core_tb.sv
